/* rtl/background_pixel_generator_top_assert.svh */
// assertion macros for the background pixel generator
// used by background_pixel_generator_top, needs clock and reset in scope
`ifndef BACKGROUND_PIXEL_GENERATOR_TOP_ASSERT_SVH
`define BACKGROUND_PIXEL_GENERATOR_TOP_ASSERT_SVH

// condition holds in the same cycle
`define BPG_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bpg check failed");

// condition holds in the next cycle
`define BPG_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bpg check failed");

`endif

/* rtl/bpg_pkg.sv */
// shared types, constants and helper functions of the background pixel generator
// no dependencies
package bpg_pkg;

   localparam int MAX_WIDTH  = 2560;
   localparam int BAND_COUNT = 96;
   localparam int GRADIENTS  = 5;

   localparam int CFG_W   = 12;
   localparam int STYLE_W = 3;
   localparam int ADDR_W  = 22;
   localparam int RGB_W   = 24;

   // divider lanes: 24-bit dividend, 12-bit divisor, one quotient bit per stage
   localparam int DVD_W     = 24;
   localparam int DSR_W     = 12;
   localparam int DIV_STEPS = DVD_W;

   // pipeline stage numbering
   localparam int MUL_STAGE  = DIV_STEPS + 1;
   localparam int OUT_STAGE  = DIV_STEPS + 2;
   localparam int NUM_STAGES = DIV_STEPS + 3;

   // reciprocal constants for the fixed divisions by the band count
   localparam int BH_SHIFT  = 20;
   localparam int BH_RECIP  = ((1 << BH_SHIFT) + BAND_COUNT - 1) / BAND_COUNT;
   localparam int MAG_W     = 19;
   localparam int Q_SHIFT   = 28;
   localparam int Q_RECIP   = ((1 << Q_SHIFT) + BAND_COUNT - 1) / BAND_COUNT;
   localparam int Q_RECIP_W = 22;

   typedef enum logic [2:0] {
      CSR_SCREEN_WIDTH  = 3'd0,
      CSR_SCREEN_HEIGHT = 3'd1,
      CSR_IMAGE_WIDTH   = 3'd2,
      CSR_IMAGE_HEIGHT  = 3'd3,
      CSR_STYLE         = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_PALETTE_WRITE = 2'd0,
      MODE_PIXEL         = 2'd1,
      MODE_SOURCE_BYTE   = 2'd2,
      MODE_UNUSED        = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_COLOUR = 2'd0,
      KIND_ADDR   = 2'd1,
      KIND_GRAD   = 2'd2
   } kind_type;

   typedef struct packed {
      logic [DSR_W-1:0] quo_a;
      logic [DVD_W-1:0] quo_b;
   } quotient_type;

   localparam logic [7:0] GRAD_TOP [GRADIENTS][3] = '{
      '{8'd22, 8'd30, 8'd48},
      '{8'd46, 8'd52, 8'd64},
      '{8'd58, 8'd42, 8'd72},
      '{8'd14, 8'd46, 8'd62},
      '{8'd38, 8'd38, 8'd40}
   };
   localparam logic [7:0] GRAD_BOT [GRADIENTS][3] = '{
      '{8'd8,  8'd12, 8'd22},
      '{8'd26, 8'd30, 8'd38},
      '{8'd20, 8'd18, 8'd38},
      '{8'd6,  8'd18, 8'd30},
      '{8'd18, 8'd18, 8'd20}
   };

   // rows per band: ceil(h / band count)
   function automatic logic [CFG_W-1:0] band_height(input logic [CFG_W-1:0] h);
      logic [CFG_W:0]          x;
      logic [CFG_W+BH_SHIFT:0] p;
      x = {1'b0, h} + (CFG_W+1)'(BAND_COUNT - 1);
      p = (CFG_W+BH_SHIFT+1)'(x) * (CFG_W+BH_SHIFT+1)'(BH_RECIP);
      return CFG_W'(p >> BH_SHIFT);
   endfunction

   // gradient index 0..4 from the style register
   function automatic logic [2:0] grad_sel(input logic [STYLE_W-1:0] style);
      logic [2:0] s;
      s = style;
      if (style == '0) s = 3'd1;
      if (style > 3'(GRADIENTS)) s = 3'(GRADIENTS);
      return s - 3'd1;
   endfunction

endpackage

/* rtl/bpg_palette.sv */
// 256 x 24 colour table, one write and one registered read per cycle
// depends on bpg_pkg
module bpg_palette (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [7:0]                wr_index,
   input  logic [bpg_pkg::RGB_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [7:0]                rd_index,
   output logic [bpg_pkg::RGB_W-1:0] rd_data
);
   import bpg_pkg::*;

   logic [RGB_W-1:0] mem_ff [256];
   logic [RGB_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_index] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_index];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/bpg_divider.sv */
// pipelined restoring divider lane, one quotient bit per stage
// depends on bpg_pkg
module bpg_divider (
   input  logic                          clock,
   input  logic [bpg_pkg::DIV_STEPS-1:0] load,
   input  logic [bpg_pkg::DVD_W-1:0]     dividend,
   input  logic [bpg_pkg::DSR_W-1:0]     divisor,
   output logic [bpg_pkg::DVD_W-1:0]     quotient
);
   import bpg_pkg::*;

   logic [DSR_W-1:0] rem_ff [DIV_STEPS];
   logic [DVD_W-1:0] dvd_ff [DIV_STEPS];
   logic [DVD_W-1:0] quo_ff [DIV_STEPS];
   logic [DSR_W-1:0] dsr_ff [DIV_STEPS];

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [DSR_W-1:0] rem_src;
      logic [DVD_W-1:0] dvd_src;
      logic [DVD_W-1:0] quo_src;
      logic [DSR_W-1:0] dsr_src;
      logic [DSR_W:0]   shifted;
      logic             ge;

      if (k == 0) begin : g_first
         assign rem_src = '0;
         assign dvd_src = dividend;
         assign quo_src = '0;
         assign dsr_src = divisor;
      end else begin : g_rest
         assign rem_src = rem_ff[k-1];
         assign dvd_src = dvd_ff[k-1];
         assign quo_src = quo_ff[k-1];
         assign dsr_src = dsr_ff[k-1];
      end

      assign shifted = {rem_src, dvd_src[DVD_W-1]};
      assign ge      = shifted >= {1'b0, dsr_src};

      always_ff @(posedge clock) begin
         if (load[k]) begin
            rem_ff[k] <= ge ? DSR_W'(shifted - {1'b0, dsr_src}) : DSR_W'(shifted);
            dvd_ff[k] <= {dvd_src[DVD_W-2:0], 1'b0};
            quo_ff[k] <= {quo_src[DVD_W-2:0], ge};
            dsr_ff[k] <= dsr_src;
         end
      end
   end

   assign quotient = quo_ff[DIV_STEPS-1];

endmodule

/* rtl/background_pixel_generator_top.sv */
// channel    | handshake              | payload
// req        | req_valid / req_stall  | mode, col, row, entry_index, red/green/blue_in
// rsp        | rsp_valid / rsp_stall  | is_address, source_address, red/green/blue_out
// csr        | csr_write              | csr_index, csr_wdata
// one item enters per cycle while req_stall is low; a result leaves through the decode stage,
// the 24 one-bit stages of the two divider lanes, then the multiply and output
// stages. each stage moves whenever the stage after it is empty or moving, so bubbles
// close up under rsp_stall. reset is synchronous, clears the valid bits and loads the
// configuration registers with their defaults; palette entries are undefined until written.
module background_pixel_generator_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_mode,
   input  logic [11:0]                req_col,
   input  logic [10:0]                req_row,
   input  logic [7:0]                 req_entry_index,
   input  logic [7:0]                 req_red_in,
   input  logic [7:0]                 req_green_in,
   input  logic [7:0]                 req_blue_in,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_is_address,
   output logic [bpg_pkg::ADDR_W-1:0] rsp_source_address,
   output logic [7:0]                 rsp_red_out,
   output logic [7:0]                 rsp_green_out,
   output logic [7:0]                 rsp_blue_out,
   input  logic                       csr_write,
   input  logic [2:0]                 csr_index,
   input  logic [bpg_pkg::CFG_W-1:0]  csr_wdata
);
   import bpg_pkg::*;
   `include "background_pixel_generator_top_assert.svh"

   // configuration
   logic [CFG_W-1:0]   screen_width_ff, screen_height_ff, image_width_ff, image_height_ff;
   logic [STYLE_W-1:0] style_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= CFG_W'(1024);
         screen_height_ff <= CFG_W'(768);
         image_width_ff   <= '0;
         image_height_ff  <= '0;
         style_ff         <= '0;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_wdata;
            CSR_SCREEN_HEIGHT: screen_height_ff <= csr_wdata;
            CSR_IMAGE_WIDTH:   image_width_ff   <= csr_wdata;
            CSR_IMAGE_HEIGHT:  image_height_ff  <= csr_wdata;
            CSR_STYLE:         style_ff         <= csr_wdata[STYLE_W-1:0];
            default: ;
         endcase
      end
   end

   // stage control
   logic     v_ff    [NUM_STAGES];
   kind_type kind_ff [NUM_STAGES];
   logic     ready   [NUM_STAGES];

   assign ready[OUT_STAGE] = !v_ff[OUT_STAGE] || !rsp_stall;
   for (genvar i = 0; i < OUT_STAGE; i++) begin : g_ready
      assign ready[i] = !v_ff[i] || ready[i+1];
   end

   logic accept;
   assign req_stall = !ready[0];
   assign accept    = req_valid && ready[0];

   // decode stage
   logic             live;
   logic             has_pic;
   kind_type         kind_in;
   logic [DSR_W-1:0] w_eff;
   logic [DVD_W-1:0] dvd_a_in, dvd_b_in;
   logic [DSR_W-1:0] dsr_a_in;
   logic [DVD_W-1:0] dvd_a_ff, dvd_b_ff;
   logic [DSR_W-1:0] dsr_a_ff, dsr_b_ff;

   always_comb begin
      has_pic = (style_ff == '0) && (image_width_ff != '0) && (image_height_ff != '0);
      w_eff   = screen_width_ff;
      if (screen_width_ff > DSR_W'(MAX_WIDTH)) w_eff = DSR_W'(MAX_WIDTH);
      if (screen_width_ff == '0) w_eff = DSR_W'(1);
      live    = 1'b0;
      kind_in = KIND_COLOUR;
      case (mode_type'(req_mode))
         MODE_SOURCE_BYTE: live = 1'b1;
         MODE_PIXEL: begin
            live    = {1'b0, req_row} < screen_height_ff;
            kind_in = has_pic ? KIND_ADDR : KIND_GRAD;
         end
         default: live = 1'b0;
      endcase
      if (has_pic) begin
         dvd_a_in = DVD_W'(req_row) * DVD_W'(image_height_ff);
         dsr_a_in = screen_height_ff;
      end else begin
         dvd_a_in = DVD_W'(req_row);
         dsr_a_in = band_height(screen_height_ff);
      end
      dvd_b_in = DVD_W'(req_col) * DVD_W'(image_width_ff);
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         kind_ff[0] <= kind_in;
         dvd_a_ff   <= dvd_a_in;
         dsr_a_ff   <= dsr_a_in;
         dvd_b_ff   <= dvd_b_in;
         dsr_b_ff   <= w_eff;
      end
   end

   logic [RGB_W-1:0] pal_rd;

   bpg_palette u_palette (
      .clock    (clock),
      .wr_en    (accept && (mode_type'(req_mode) == MODE_PALETTE_WRITE)),
      .wr_index (req_entry_index),
      .wr_data  ({req_red_in, req_green_in, req_blue_in}),
      .rd_en    (accept && (mode_type'(req_mode) == MODE_SOURCE_BYTE)),
      .rd_index (req_entry_index),
      .rd_data  (pal_rd)
   );

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (ready[0]) begin
         v_ff[0] <= req_valid && live;
      end
   end

   for (genvar i = 1; i < NUM_STAGES; i++) begin : g_pipe
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (ready[i]) begin
            v_ff[i] <= v_ff[i-1];
         end
      end
      always_ff @(posedge clock) begin
         if (ready[i]) begin
            kind_ff[i] <= kind_ff[i-1];
         end
      end
   end

   // palette colour rides along the divider stages
   logic [RGB_W-1:0] rgb_ff [1:MUL_STAGE];
   for (genvar i = 1; i <= MUL_STAGE; i++) begin : g_rgb
      always_ff @(posedge clock) begin
         if (ready[i]) begin
            rgb_ff[i] <= (i == 1) ? pal_rd : rgb_ff[(i == 1) ? 1 : i-1];
         end
      end
   end

   // divider lanes
   logic [DIV_STEPS-1:0] div_load;
   logic [DVD_W-1:0]     quo_a, quo_b;
   quotient_type         quo;

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_load
      assign div_load[k] = ready[k+1];
   end

   bpg_divider u_div_a (
      .clock    (clock),
      .load     (div_load),
      .dividend (dvd_a_ff),
      .divisor  (dsr_a_ff),
      .quotient (quo_a)
   );

   bpg_divider u_div_b (
      .clock    (clock),
      .load     (div_load),
      .dividend (dvd_b_ff),
      .divisor  (dsr_b_ff),
      .quotient (quo_b)
   );

   assign quo.quo_a = quo_a[DSR_W-1:0];
   assign quo.quo_b = quo_b;

   // multiply stage: source row times width, band times colour span
   logic [2:0]        sel;
   logic [DVD_W-1:0]  prod_ff;
   logic [ADDR_W-1:0] scol_ff;
   logic [MAG_W-1:0]  mag_ff [3];
   logic [7:0]        span   [3];

   assign sel = grad_sel(style_ff);

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         span[c] = (GRAD_TOP[sel][c] >= GRAD_BOT[sel][c]) ?
                   GRAD_TOP[sel][c] - GRAD_BOT[sel][c] :
                   GRAD_BOT[sel][c] - GRAD_TOP[sel][c];
      end
   end

   always_ff @(posedge clock) begin
      if (ready[MUL_STAGE]) begin
         prod_ff <= DVD_W'(quo.quo_a) * DVD_W'(image_width_ff);
         scol_ff <= quo.quo_b[ADDR_W-1:0];
         for (int c = 0; c < 3; c++) begin
            mag_ff[c] <= MAG_W'(span[c]) * MAG_W'(quo.quo_a[10:0]);
         end
      end
   end

   // output stage
   logic [7:0]                   chan  [3];
   logic [MAG_W+Q_RECIP_W-1:0]   qprod [3];
   logic [7:0]                   qband [3];
   logic                         is_addr_ff;
   logic [ADDR_W-1:0]            addr_ff;
   logic [RGB_W-1:0]             rgb_out_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         qprod[c] = (MAG_W+Q_RECIP_W)'(mag_ff[c]) * (MAG_W+Q_RECIP_W)'(Q_RECIP);
         qband[c] = 8'(qprod[c] >> Q_SHIFT);
         chan[c]  = (GRAD_BOT[sel][c] < GRAD_TOP[sel][c]) ?
                    GRAD_TOP[sel][c] - qband[c] : GRAD_TOP[sel][c] + qband[c];
      end
   end

   always_ff @(posedge clock) begin
      if (ready[OUT_STAGE]) begin
         case (kind_ff[MUL_STAGE])
            KIND_ADDR: begin
               is_addr_ff <= 1'b1;
               addr_ff    <= prod_ff[ADDR_W-1:0] + scol_ff;
               rgb_out_ff <= '0;
            end
            KIND_GRAD: begin
               is_addr_ff <= 1'b0;
               addr_ff    <= '0;
               rgb_out_ff <= {chan[0], chan[1], chan[2]};
            end
            default: begin
               is_addr_ff <= 1'b0;
               addr_ff    <= '0;
               rgb_out_ff <= rgb_ff[MUL_STAGE];
            end
         endcase
      end
   end

   assign rsp_valid          = v_ff[OUT_STAGE];
   assign rsp_is_address     = is_addr_ff;
   assign rsp_source_address = addr_ff;
   assign rsp_red_out        = rgb_out_ff[23:16];
   assign rsp_green_out      = rgb_out_ff[15:8];
   assign rsp_blue_out       = rgb_out_ff[7:0];

   `BPG_ASSERT_SAME(a_stall_needs_full, req_stall, rsp_valid && rsp_stall && v_ff[0])
   `BPG_ASSERT_SAME(a_addr_no_colour, rsp_valid && rsp_is_address, rgb_out_ff == '0)
   `BPG_ASSERT_NEXT(a_out_holds, rsp_valid && rsp_stall, rsp_valid)

endmodule

/* test/tb_background_pixel_generator_top.sv */
// testbench for background_pixel_generator_top: random and directed words, self-checking
// needs bpg_pkg and the rtl of background_pixel_generator_top
module tb_background_pixel_generator_top;
   timeunit 1ns;
   timeprecision 1ps;
   import bpg_pkg::*;

   typedef struct packed {
      mode_type   mode;
      logic [11:0] col;
      logic [10:0] row;
      logic [7:0]  entry_index;
      logic [7:0]  red_in;
      logic [7:0]  green_in;
      logic [7:0]  blue_in;
   } pixel_req_type;

   typedef struct packed {
      logic        is_address;
      logic [21:0] source_address;
      logic [7:0]  red_out;
      logic [7:0]  green_out;
      logic [7:0]  blue_out;
   } pixel_rsp_type;

   localparam int LIMIT = 2000000;
   localparam int TOP_R [5] = '{22, 46, 58, 14, 38};
   localparam int TOP_G [5] = '{30, 52, 42, 46, 38};
   localparam int TOP_B [5] = '{48, 64, 72, 62, 40};
   localparam int BOT_R [5] = '{8, 26, 20, 6, 18};
   localparam int BOT_G [5] = '{12, 30, 18, 18, 18};
   localparam int BOT_B [5] = '{22, 38, 38, 30, 20};

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_stall;
   logic [1:0] req_mode = 0;
   logic [11:0] req_col = 0;
   logic [10:0] req_row = 0;
   logic [7:0] req_entry_index = 0, req_red_in = 0, req_green_in = 0, req_blue_in = 0;
   logic rsp_valid, rsp_stall = 0, rsp_is_address;
   logic [21:0] rsp_source_address;
   logic [7:0] rsp_red_out, rsp_green_out, rsp_blue_out;
   logic csr_write = 0;
   logic [2:0] csr_index = 0;
   logic [11:0] csr_wdata = 0;

   background_pixel_generator_top dut (.*);

   always #1 clock = ~clock;

   // predictor state
   logic [11:0] scr_w, scr_h, img_w, img_h;
   logic [2:0]  bg_style;
   logic [23:0] palette [256];
   bit          written [256];

   pixel_req_type pending_words [$];
   pixel_rsp_type expected_pixels [$];
   int send_idle_pct = 0, recv_idle_pct = 0;
   int errors = 0;
   longint cycles = 0;

   function automatic int band_channel(int top, int bot, int band);
      return top + ((bot - top) * band) / BAND_COUNT;
   endfunction

   // returns 1 when the word yields a pixel result
   function automatic bit predict_pixel(pixel_req_type w, output pixel_rsp_type r);
      longint sw, src_row, src_col;
      int sel, bh, band;
      r = '0;
      case (w.mode)
         MODE_PALETTE_WRITE: begin
            palette[w.entry_index] = {w.red_in, w.green_in, w.blue_in};
            written[w.entry_index] = 1;
            return 0;
         end
         MODE_SOURCE_BYTE: begin
            {r.red_out, r.green_out, r.blue_out} = palette[w.entry_index];
            return 1;
         end
         MODE_PIXEL: begin
            if (w.row >= scr_h) return 0;
            if (bg_style == 0 && img_w != 0 && img_h != 0) begin
               sw = scr_w > MAX_WIDTH ? MAX_WIDTH : scr_w;
               if (sw == 0) sw = 1;
               src_row = (longint'(w.row) * img_h) / scr_h;
               src_col = (longint'(w.col) * img_w) / sw;
               r.is_address = 1;
               r.source_address = 22'(src_row * img_w + src_col);
               return 1;
            end
            sel = bg_style == 0 ? 1 : (bg_style > 5 ? 5 : bg_style);
            sel = sel - 1;
            bh = (scr_h + BAND_COUNT - 1) / BAND_COUNT;
            band = w.row / bh;
            r.red_out = 8'(band_channel(TOP_R[sel], BOT_R[sel], band));
            r.green_out = 8'(band_channel(TOP_G[sel], BOT_G[sel], band));
            r.blue_out = 8'(band_channel(TOP_B[sel], BOT_B[sel], band));
            return 1;
         end
         default: return 0;
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      pixel_req_type w;
      pixel_rsp_type r;
      cycles <= cycles + 1;
      rsp_stall <= !reset && ($urandom_range(99) < recv_idle_pct);
      if (reset) begin
         req_valid <= 0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid && !req_stall) begin
            if (predict_pixel(pending_words[0], r)) expected_pixels.push_back(r);
            void'(pending_words.pop_front());
         end
         if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            w = pending_words[0];
            req_valid <= 1;
            req_mode <= w.mode;
            req_col <= w.col;
            req_row <= w.row;
            req_entry_index <= w.entry_index;
            req_red_in <= w.red_in;
            req_green_in <= w.green_in;
            req_blue_in <= w.blue_in;
         end else begin
            req_valid <= 0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      pixel_rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected result word");
            errors++;
         end else begin
            e = expected_pixels.pop_front();
            if (rsp_is_address !== e.is_address) begin
               $error("is_address exp %0h got %0h", e.is_address, rsp_is_address);
               errors++;
            end
            if (rsp_source_address !== e.source_address) begin
               $error("source_address exp %0h got %0h", e.source_address,
                  rsp_source_address);
               errors++;
            end
            if (rsp_red_out !== e.red_out) begin
               $error("red_out exp %0h got %0h", e.red_out, rsp_red_out);
               errors++;
            end
            if (rsp_green_out !== e.green_out) begin
               $error("green_out exp %0h got %0h", e.green_out, rsp_green_out);
               errors++;
            end
            if (rsp_blue_out !== e.blue_out) begin
               $error("blue_out exp %0h got %0h", e.blue_out, rsp_blue_out);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > LIMIT) begin
         $display("background_pixel_generator_top verification failed");
         $finish;
      end
   end

   function automatic pixel_req_type make_word(mode_type m, int c, int rw, int idx,
                                               logic [23:0] rgb);
      pixel_req_type w;
      w.mode = m;
      w.col = 12'(c);
      w.row = 11'(rw);
      w.entry_index = 8'(idx);
      {w.red_in, w.green_in, w.blue_in} = rgb;
      return w;
   endfunction

   task automatic drain();
      while (pending_words.size() != 0 || req_valid || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [11:0] val);
      @(posedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 0;
      case (idx)
         CSR_SCREEN_WIDTH: scr_w = val;
         CSR_SCREEN_HEIGHT: scr_h = val;
         CSR_IMAGE_WIDTH: img_w = val;
         CSR_IMAGE_HEIGHT: img_h = val;
         default: bg_style = val[2:0];
      endcase
   endtask

   task automatic set_screen(int sw, int sh, int iw, int ih, int st);
      drain();
      write_reg(CSR_SCREEN_WIDTH, 12'(sw));
      write_reg(CSR_SCREEN_HEIGHT, 12'(sh));
      write_reg(CSR_IMAGE_WIDTH, 12'(iw));
      write_reg(CSR_IMAGE_HEIGHT, 12'(ih));
      write_reg(CSR_STYLE, 12'(st));
   endtask

   // mostly in-range pixels, some past height, palette traffic, a few unused modes
   task automatic queue_random(int n);
      int k, p;
      logic [7:0] idx;
      for (k = 0; k < n; k++) begin
         p = $urandom_range(99);
         idx = 8'($urandom);
         if (p < 15) begin
            pending_words.push_back(make_word(MODE_PALETTE_WRITE, $urandom, $urandom, idx,
               24'($urandom)));
            written[idx] = 1;
         end else if (p < 30) begin
            while (!written[idx]) idx = 8'($urandom);
            pending_words.push_back(make_word(MODE_SOURCE_BYTE, $urandom, $urandom, idx,
               24'($urandom)));
         end else if (p < 33) begin
            pending_words.push_back(make_word(MODE_UNUSED, $urandom, $urandom, $urandom,
               24'($urandom)));
         end else if (p < 85 && scr_h > 0) begin
            pending_words.push_back(make_word(MODE_PIXEL, $urandom_range(4095),
               $urandom_range(scr_h > 2047 ? 2047 : scr_h - 1), $urandom, 24'($urandom)));
         end else begin
            pending_words.push_back(make_word(MODE_PIXEL, $urandom, $urandom, $urandom,
               24'($urandom)));
         end
      end
   endtask

   initial begin
      int ph;
      scr_w = 1024; scr_h = 768; img_w = 0; img_h = 0; bg_style = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      // written[] in queue_random tracks what will be written before the read is sent
      pending_words.push_back(make_word(MODE_PALETTE_WRITE, 0, 0, 0, 24'h000000));
      pending_words.push_back(make_word(MODE_PALETTE_WRITE, 0, 0, 255, 24'hffffff));
      pending_words.push_back(make_word(MODE_SOURCE_BYTE, 0, 0, 0, 0));
      pending_words.push_back(make_word(MODE_SOURCE_BYTE, 4095, 2047, 255, 0));
      written[0] = 1; written[255] = 1;
      // default config: no picture falls back to gradient
      pending_words.push_back(make_word(MODE_PIXEL, 0, 0, 0, 0));
      pending_words.push_back(make_word(MODE_PIXEL, 1023, 767, 0, 0));
      pending_words.push_back(make_word(MODE_PIXEL, 5, 768, 0, 0));
      pending_words.push_back(make_word(MODE_PIXEL, 4095, 2047, 0, 0));
      pending_words.push_back(make_word(MODE_UNUSED, 4095, 2047, 255, 24'hffffff));
      // picture at extremes, column past width wraps the address
      set_screen(2560, 2048, 2048, 2048, 0);
      pending_words.push_back(make_word(MODE_PIXEL, 0, 0, 0, 0));
      pending_words.push_back(make_word(MODE_PIXEL, 2559, 2047, 0, 0));
      pending_words.push_back(make_word(MODE_PIXEL, 4095, 2047, 0, 0));
      set_screen(4095, 1, 2048, 1, 0);
      pending_words.push_back(make_word(MODE_PIXEL, 4095, 0, 0, 0));
      pending_words.push_back(make_word(MODE_PIXEL, 3, 1, 0, 0));
      // zero width, zero height, odd styles
      set_screen(0, 0, 7, 9, 0);
      pending_words.push_back(make_word(MODE_PIXEL, 1, 0, 0, 0));
      set_screen(0, 4095, 7, 9, 0);
      pending_words.push_back(make_word(MODE_PIXEL, 5, 2047, 0, 0));
      set_screen(100, 1, 0, 9, 6);
      pending_words.push_back(make_word(MODE_PIXEL, 5, 0, 0, 0));
      set_screen(100, 2048, 5, 0, 7);
      pending_words.push_back(make_word(MODE_PIXEL, 5, 2047, 0, 0));
      // random phases over several settings and idling regimes
      for (ph = 0; ph < 9; ph++) begin
         send_idle_pct = ph < 3 ? 23 : (ph < 6 ? 62 : 0);
         recv_idle_pct = ph < 3 ? 62 : (ph < 6 ? 23 : 0);
         case (ph % 3)
            0: set_screen($urandom_range(1, 2560), $urandom_range(1, 2048),
                  $urandom_range(1, 2048), $urandom_range(1, 2048), 0);
            1: set_screen($urandom_range(4095), $urandom_range(1, 4095),
                  $urandom_range(2048), $urandom_range(2048), $urandom_range(7));
            default: set_screen($urandom_range(16, 64), $urandom_range(1, 300),
                  $urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(1, 5));
         endcase
         queue_random(28);
         drain();  // sender waits for every result
         queue_random(28);
      end
      drain();
      if (errors == 0) begin
         $display("background_pixel_generator_top verification clean");
      end else begin
         $display("background_pixel_generator_top verification failed");
      end
      $finish;
   end
endmodule
